// File: hdl/uvc_pkg.sv
// ----------------------------------------------------------------------------
// uvc_pkg
// Shared types and constants for the 16-bit unit vector compressor.
// ----------------------------------------------------------------------------
package uvc_pkg;

	localparam int unsigned CompW   = 16;
	localparam int unsigned MagW    = CompW + 1;
	localparam int unsigned SumW    = MagW;
	localparam int unsigned QBits   = 7;
	localparam int unsigned RemW    = 22;
	localparam int unsigned DvsW    = SumW + QBits - 1;
	localparam int unsigned XbW     = 6;
	localparam int unsigned YbW     = 7;
	localparam int unsigned CodeW   = 16;

	localparam logic [QBits-1:0] FoldBase = 7'd127;

	typedef struct packed {
		logic [2:0]        sgn;
		logic              zero;
		logic [DvsW-1:0]   dvs;
		logic [RemW-1:0]   rx;
		logic [RemW-1:0]   ry;
		logic [QBits-1:0]  qx;
		logic [QBits-1:0]  qy;
	} uvc_work_t;

endpackage

// File: hdl/uvc_front.sv
// ----------------------------------------------------------------------------
// uvc_front
// Sign split, magnitudes, sum and scaled numerators; loads the divider chain.
// ----------------------------------------------------------------------------
module uvc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [uvc_pkg::CompW-1:0] x_component,
	input  logic [uvc_pkg::CompW-1:0] y_component,
	input  logic [uvc_pkg::CompW-1:0] z_component,
	output logic                      out_valid,
	input  logic                      out_stall,
	output uvc_pkg::uvc_work_t        out_data
);

	logic [uvc_pkg::MagW-1:0] xe, ye, ze;
	logic [uvc_pkg::MagW-1:0] ax, ay, az;
	logic [uvc_pkg::SumW-1:0] sum;
	uvc_pkg::uvc_work_t       work;
	logic                     valid_q;
	uvc_pkg::uvc_work_t       data_q;

	assign xe = {x_component[uvc_pkg::CompW-1], x_component};
	assign ye = {y_component[uvc_pkg::CompW-1], y_component};
	assign ze = {z_component[uvc_pkg::CompW-1], z_component};

	assign ax = x_component[uvc_pkg::CompW-1] ? (~xe + 17'd1) : xe;
	assign ay = y_component[uvc_pkg::CompW-1] ? (~ye + 17'd1) : ye;
	assign az = z_component[uvc_pkg::CompW-1] ? (~ze + 17'd1) : ze;

	assign sum = ax + ay + az;

	always_comb begin
		work.sgn  = {x_component[uvc_pkg::CompW-1], y_component[uvc_pkg::CompW-1],
			z_component[uvc_pkg::CompW-1]};
		work.zero = (sum == '0);
		work.dvs  = {sum, 6'd0};
		work.rx   = {ax[14:0], 7'd0} - {4'd0, ax[16:0], 1'b0};
		work.ry   = {ay[14:0], 7'd0} - {4'd0, ay[16:0], 1'b0};
		work.qx   = '0;
		work.qy   = '0;
	end

	assign in_stall = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_q <= work;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: hdl/uvc_div_cell.sv
// ----------------------------------------------------------------------------
// uvc_div_cell
// One restoring-division step: one quotient bit for x and for y per cell.
// ----------------------------------------------------------------------------
module uvc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  uvc_pkg::uvc_work_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output uvc_pkg::uvc_work_t out_data
);

	logic               ge_x, ge_y;
	uvc_pkg::uvc_work_t work;
	logic               valid_q;
	uvc_pkg::uvc_work_t data_q;

	assign ge_x = {1'b0, in_data.rx} >= in_data.dvs;
	assign ge_y = {1'b0, in_data.ry} >= in_data.dvs;

	always_comb begin
		work      = in_data;
		work.rx   = ge_x ? (in_data.rx - in_data.dvs[uvc_pkg::RemW-1:0]) : in_data.rx;
		work.ry   = ge_y ? (in_data.ry - in_data.dvs[uvc_pkg::RemW-1:0]) : in_data.ry;
		work.qx   = {in_data.qx[uvc_pkg::QBits-2:0], ge_x};
		work.qy   = {in_data.qy[uvc_pkg::QBits-2:0], ge_y};
		work.dvs  = {1'b0, in_data.dvs[uvc_pkg::DvsW-1:1]};
	end

	assign in_stall = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_q <= work;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: hdl/uvc_pack.sv
// ----------------------------------------------------------------------------
// uvc_pack
// Fold the quotients into the 64 x 128 rectangle and register the code.
// ----------------------------------------------------------------------------
module uvc_pack (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  uvc_pkg::uvc_work_t        in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [uvc_pkg::CodeW-1:0] packed_code,
	output logic                      zero_vector
);

	logic [uvc_pkg::QBits-1:0] xb, yb;
	logic [uvc_pkg::CodeW-1:0] code;
	logic                      valid_q;
	logic [uvc_pkg::CodeW-1:0] code_q;
	logic                      zero_q;

	always_comb begin
		if (in_data.zero) begin
			xb = '0;
			yb = '0;
		end else if (in_data.qx[uvc_pkg::QBits-1]) begin
			xb = uvc_pkg::FoldBase - in_data.qx;
			yb = uvc_pkg::FoldBase - in_data.qy;
		end else begin
			xb = in_data.qx;
			yb = in_data.qy;
		end
		code = {in_data.sgn, xb[uvc_pkg::XbW-1:0], yb[uvc_pkg::YbW-1:0]};
	end

	assign in_stall = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			code_q <= code;
			zero_q <= in_data.zero;
		end
	end

	assign out_valid   = valid_q;
	assign packed_code = code_q;
	assign zero_vector = zero_q;

endmodule

// File: hdl/unit_vector_compress_16bit_unit.sv
// Pipeline: front, 7 division cells, pack; each is a registered stage.
// Throughput: one beat per cycle while out_stall is low; each cell holds one beat and stalls only when full.
// The 7-cell restoring divider chain forms most of the pipeline, one quotient bit per cell.
// Reset: arst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// unit_vector_compress_16bit_unit
// Packs a signed 3D direction into a 16-bit octahedral-style code.
// ----------------------------------------------------------------------------
module unit_vector_compress_16bit_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [uvc_pkg::CompW-1:0] x_component,
	input  logic [uvc_pkg::CompW-1:0] y_component,
	input  logic [uvc_pkg::CompW-1:0] z_component,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [uvc_pkg::CodeW-1:0] packed_code,
	output logic                      zero_vector
);

	logic               chain_valid [uvc_pkg::QBits+1];
	logic               chain_stall [uvc_pkg::QBits+1];
	uvc_pkg::uvc_work_t chain_data  [uvc_pkg::QBits+1];

	uvc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_component (x_component),
		.y_component (y_component),
		.z_component (z_component),
		.out_valid   (chain_valid[0]),
		.out_stall   (chain_stall[0]),
		.out_data    (chain_data[0])
	);

	for (genvar i = 0; i < uvc_pkg::QBits; i++) begin : g_cell
		uvc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_stall  (chain_stall[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_stall (chain_stall[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	uvc_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (chain_valid[uvc_pkg::QBits]),
		.in_stall    (chain_stall[uvc_pkg::QBits]),
		.in_data     (chain_data[uvc_pkg::QBits]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_code (packed_code),
		.zero_vector (zero_vector)
	);

endmodule

// File: hdl/uvc_checker.sv
// ----------------------------------------------------------------------------
// uvc_checker
// Port-level checks for the unit vector compressor, bound to the top level.
// ----------------------------------------------------------------------------
module uvc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [uvc_pkg::CompW-1:0] x_component,
	input logic [uvc_pkg::CompW-1:0] y_component,
	input logic [uvc_pkg::CompW-1:0] z_component,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [uvc_pkg::CodeW-1:0] packed_code,
	input logic                      zero_vector
);

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> packed_code == '0)
		else $error("zero vector beat carries a nonzero code");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packed_code) && $stable(zero_vector))
		else $error("stalled output beat changed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");

endmodule

bind unit_vector_compress_16bit_unit uvc_checker u_chk (.*);

// File: tb/unit_vector_compress_16bit_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unit_vector_compress_16bit_unit_tb
// Self-checking bench for the 16-bit unit vector compressor. An in-bench
// predictor computes the sign bits, the folded plane coordinates and the
// zero flag of every accepted vector. Each output beat is compared in order.
// Directed corner vectors run first, then random streams with gaps and
// stalls on both sides, a long receiver hold and a full drain pause.
// ----------------------------------------------------------------------------
module unit_vector_compress_16bit_unit_tb;

	localparam int unsigned CW            = uvc_pkg::CompW;
	localparam int unsigned OW            = uvc_pkg::CodeW;
	localparam int unsigned PlaneScale    = 126;
	localparam int unsigned FoldLimit     = 64;
	localparam int unsigned SinkHoldCycles = 120;
	localparam int unsigned DrainCycles   = 20;
	localparam int unsigned CycleLimit    = 200000;

	typedef struct {
		logic [OW-1:0] code;
		logic          zero;
	} compressed_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [CW-1:0] x_component;
	logic [CW-1:0] y_component;
	logic [CW-1:0] z_component;
	logic          out_valid;
	logic          out_stall;
	logic [OW-1:0] packed_code;
	logic          zero_vector;

	compressed_t pending_codes[$];
	int unsigned mismatches;
	int unsigned cycle_count;
	bit          sender_gaps;
	bit          sink_stalls;
	bit          hold_sink;

	unit_vector_compress_16bit_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_component(x_component),
		.y_component(y_component),
		.z_component(z_component),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packed_code(packed_code),
		.zero_vector(zero_vector)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [CW:0] abs_component(input logic [CW-1:0] c);
		if (c[CW-1])
			return (CW+1)'(1 << CW) - {1'b0, c};
		return {1'b0, c};
	endfunction

	function automatic void compress_direction(input logic [CW-1:0] xc, input logic [CW-1:0] yc,
			input logic [CW-1:0] zc, output compressed_t res);
		logic [CW:0]   ax;
		logic [CW:0]   ay;
		logic [CW:0]   az;
		logic [CW+1:0] total;
		logic [22:0]   xb;
		logic [22:0]   yb;
		ax = abs_component(xc);
		ay = abs_component(yc);
		az = abs_component(zc);
		total = ax + ay + az;
		xb = '0;
		yb = '0;
		res.zero = (total == '0);
		if (!res.zero) begin
			xb = (23'(ax) * 23'(PlaneScale)) / 23'(total);
			yb = (23'(ay) * 23'(PlaneScale)) / 23'(total);
			if (xb >= 23'(FoldLimit)) begin
				xb = 23'(uvc_pkg::FoldBase) - xb;
				yb = 23'(uvc_pkg::FoldBase) - yb;
			end
		end
		res.code = {xc[CW-1], yc[CW-1], zc[CW-1], xb[5:0], yb[6:0]};
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [CW-1:0] pick_component(input int unsigned style);
		logic [CW-1:0] mag;
		case (style)
			0: return CW'($urandom);
			1: begin
				mag = CW'($urandom_range(0, 300));
				return $urandom_range(0, 1) ? -mag : mag;
			end
			2: return CW'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
			default: return '0;
		endcase
	endfunction

	function automatic int unsigned pick_style();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 0;
		if (r < 70)
			return 1;
		if (r < 80)
			return 2;
		return 3;
	endfunction

	task automatic drive_vector(input logic [CW-1:0] xc, input logic [CW-1:0] yc,
			input logic [CW-1:0] zc);
		int unsigned gap;
		compressed_t want;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		x_component <= xc;
		y_component <= yc;
		z_component <= zc;
		compress_direction(xc, yc, zc, want);
		do @(posedge clk); while (in_stall);
		pending_codes.push_back(want);
		@(negedge clk);
	endtask

	task automatic await_drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_codes.size() != 0);
	endtask

	task automatic drive_mixed_vector();
		if ($urandom_range(0, 24) == 0)
			drive_vector('0, '0, '0);
		else
			drive_vector(pick_component(pick_style()), pick_component(pick_style()),
				pick_component(pick_style()));
	endtask

	task automatic test_corner_vectors();
		drive_vector(16'h0000, 16'h0000, 16'h0000);
		drive_vector(16'h8000, 16'h8000, 16'h8000);
		drive_vector(16'h7fff, 16'h7fff, 16'h7fff);
		drive_vector(16'h7fff, 16'h0000, 16'h0000);
		drive_vector(16'h8000, 16'h0000, 16'h0000);
		drive_vector(16'h0000, 16'h7fff, 16'h0000);
		drive_vector(16'h0000, 16'h8000, 16'h0000);
		drive_vector(16'h0000, 16'h0000, 16'h7fff);
		drive_vector(16'h0000, 16'h0000, 16'hffff);
		drive_vector(16'h0001, 16'h0000, 16'h0000);
		drive_vector(16'hffff, 16'hffff, 16'hffff);
		drive_vector(16'h0001, 16'h0001, 16'h0001);
		drive_vector(16'h7fff, 16'h8000, 16'h7fff);
		drive_vector(16'h0040, 16'h0000, 16'h003e);
		drive_vector(16'h003f, 16'h0000, 16'h003f);
		drive_vector(16'hffc0, 16'h0000, 16'hffc2);
		drive_vector(16'h0000, 16'h0001, 16'h8000);
		drive_vector(16'h8000, 16'h7fff, 16'h0000);
		await_drain();
	endtask

	task automatic test_full_range_stream();
		repeat (250)
			drive_vector(CW'($urandom), CW'($urandom), CW'($urandom));
		await_drain();
	endtask

	task automatic test_mixed_magnitudes();
		repeat (150)
			drive_mixed_vector();
		await_drain();
	endtask

	task automatic test_backpressure_fill();
		sender_gaps = 1'b0;
		hold_sink   = 1'b1;
		repeat (40)
			drive_mixed_vector();
		sender_gaps = 1'b1;
		await_drain();
	endtask

	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (60)
			drive_vector(CW'($urandom), CW'($urandom), CW'($urandom));
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		await_drain();
	endtask

	task automatic test_drain_pause();
		repeat (30)
			drive_mixed_vector();
		await_drain();
		repeat (30)
			drive_mixed_vector();
		await_drain();
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_stall <= 1'b1;
				repeat (SinkHoldCycles) @(negedge clk);
				hold_sink = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
				out_stall <= 1'b1;
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
					: $urandom_range(6, 30);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		compressed_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				$error("unexpected beat: packed_code %h zero_vector %b",
					packed_code, zero_vector);
				mismatches++;
			end else begin
				want = pending_codes.pop_front();
				if (packed_code !== want.code) begin
					$error("packed_code: expected %h, got %h", want.code, packed_code);
					mismatches++;
				end
				if (zero_vector !== want.zero) begin
					$error("zero_vector: expected %b, got %b", want.zero, zero_vector);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		x_component = '0;
		y_component = '0;
		z_component = '0;
		mismatches  = 0;
		cycle_count = 0;
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		hold_sink   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_corner_vectors();
		test_full_range_stream();
		test_mixed_magnitudes();
		test_backpressure_fill();
		test_back_to_back();
		test_drain_pause();
		await_drain();
		repeat (DrainCycles) @(negedge clk);
		if (mismatches == 0 && pending_codes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
